>>> hdl/nus_pkg.sv
// ----------------------------------------------------------------------------
// NAL unit splitter package
// Shared constants and width helpers for the Annex B start code parser.
// ----------------------------------------------------------------------------
package nus_pkg;

   // Default widths of the internal counters and depth of the queue
   localparam int NUS_LENGTH_BITS = 24;
   localparam int NUS_OFFSET_BITS = 32;
   localparam int NUS_QUEUE_DEPTH = 4;

   // Fixed widths of the ports
   localparam int MAX_LENGTH_W  = 24;
   localparam int OFFSET_OUT_W  = 32;
   localparam int PREFIX_W      = 3;
   localparam int PAYLOAD_OUT_W = 24;

   localparam logic [MAX_LENGTH_W-1:0] MAX_LENGTH_RESET = 24'd100000;

   // Start code detection
   localparam logic [23:0]         HIST_RESET      = 24'hFF_FFFF;
   localparam logic [7:0]          START_CODE_LAST = 8'h01;
   localparam logic [PREFIX_W-1:0] PREFIX_SHORT    = 3'd3;
   localparam logic [PREFIX_W-1:0] PREFIX_LONG     = 3'd4;
   localparam int                  ZEROS_SHORT     = 2;
   localparam int                  ZEROS_LONG      = 3;

   // NAL header byte layout
   localparam int HDR_FORBIDDEN_POS = 7;
   localparam int HDR_REF_IDC_HI    = 6;
   localparam int HDR_REF_IDC_LO    = 5;
   localparam int HDR_TYPE_HI       = 4;

   // Raw descriptor: offset, prefix, count, header, skip flag, end flag
   function automatic int nus_desc_bits(input int length_bits, input int offset_bits);
      return offset_bits + PREFIX_W + (length_bits + 1) + 8 + 1 + 1;
   endfunction

   // Queue entry: two descriptors and a flag that the second one is used
   function automatic int nus_pair_bits(input int length_bits, input int offset_bits);
      return 2 * nus_desc_bits(length_bits, offset_bits) + 1;
   endfunction

endpackage

>>> hdl/nus_front.sv
// ----------------------------------------------------------------------------
// NAL unit splitter front end
// Accepts stream bytes, tracks start codes and builds raw descriptors.
// ----------------------------------------------------------------------------
module nus_front import nus_pkg::*; #(
   parameter int LENGTH_BITS = NUS_LENGTH_BITS,
   parameter int OFFSET_BITS = NUS_OFFSET_BITS,
   parameter int PAIR_W      = nus_pair_bits(NUS_LENGTH_BITS, NUS_OFFSET_BITS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last_byte,
   input  logic              q_full,
   output logic              q_push,
   output logic [PAIR_W-1:0] q_wdata
);

   localparam int CNT_W = LENGTH_BITS + 1;
   localparam logic [CNT_W-1:0] COUNT_CAP =
      CNT_W'((64'd1 << LENGTH_BITS) + 64'd3);

   typedef struct packed {
      logic [OFFSET_BITS-1:0] offset;
      logic [PREFIX_W-1:0]    prefix;
      logic [CNT_W-1:0]       len;
      logic [7:0]             hdr;
      logic                   skip;
      logic                   eos;
   } desc_type;

   typedef struct packed {
      logic     two;
      desc_type second;
      desc_type first;
   } pair_type;

   logic [23:0]            hist_ff, hist_in;
   logic                   in_nal_ff, in_nal_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [PREFIX_W-1:0]    prefix_ff, prefix_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [7:0]             hdr_ff, hdr_in;
   logic                   skip_ff, skip_in;

   logic                   accept;
   logic                   four, three, found;
   logic [CNT_W-1:0]       zeros;
   logic [OFFSET_BITS-1:0] sc_start;
   logic                   close_nal, end_nal;
   desc_type               d_close, d_end;
   pair_type               pair;

   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;

   assign four     = (hist_ff == 24'd0) && (req_data_byte == START_CODE_LAST);
   assign three    = (hist_ff[15:0] == 16'd0) && (req_data_byte == START_CODE_LAST);
   assign found    = four | three;
   assign zeros    = four ? CNT_W'(ZEROS_LONG) : CNT_W'(ZEROS_SHORT);
   assign sc_start = pos_ff - OFFSET_BITS'(zeros);

   // Next stream state for one byte
   always_comb begin
      in_nal_in = in_nal_ff;
      start_in  = start_ff;
      prefix_in = prefix_ff;
      cnt_in    = cnt_ff;
      hdr_in    = hdr_ff;
      skip_in   = skip_ff;
      if (found) begin
         if (!in_nal_ff) begin
            skip_in = (sc_start != '0);
         end
         in_nal_in = 1'b1;
         start_in  = sc_start;
         prefix_in = four ? PREFIX_LONG : PREFIX_SHORT;
         cnt_in    = '0;
         hdr_in    = '0;
      end else if (in_nal_ff) begin
         if (cnt_ff == '0) begin
            hdr_in = req_data_byte;
         end
         if (cnt_ff < COUNT_CAP) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
      hist_in = {hist_ff[15:0], req_data_byte};
      pos_in  = pos_ff + 1'b1;
   end

   // Descriptors: the one a start code closes, the one the last byte closes
   always_comb begin
      close_nal = found & in_nal_ff;
      end_nal   = req_last_byte & in_nal_in;

      d_close.offset = start_ff;
      d_close.prefix = prefix_ff;
      d_close.len    = (cnt_ff >= zeros) ? (cnt_ff - zeros) : '0;
      d_close.hdr    = hdr_ff;
      d_close.skip   = skip_ff;
      d_close.eos    = 1'b0;

      d_end.offset = start_in;
      d_end.prefix = prefix_in;
      d_end.len    = cnt_in;
      d_end.hdr    = hdr_in;
      d_end.skip   = skip_in;
      d_end.eos    = 1'b1;

      pair.first  = close_nal ? d_close : d_end;
      pair.second = d_end;
      pair.two    = close_nal & end_nal;
   end

   assign q_push  = accept & (close_nal | end_nal);
   assign q_wdata = pair;

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff   <= HIST_RESET;
         in_nal_ff <= 1'b0;
         pos_ff    <= '0;
         start_ff  <= '0;
         prefix_ff <= PREFIX_SHORT;
         cnt_ff    <= '0;
         hdr_ff    <= '0;
         skip_ff   <= 1'b0;
      end else if (accept) begin
         if (req_last_byte) begin
            // drop all stream state, a new stream starts at position zero
            hist_ff   <= HIST_RESET;
            in_nal_ff <= 1'b0;
            pos_ff    <= '0;
            start_ff  <= '0;
            prefix_ff <= PREFIX_SHORT;
            cnt_ff    <= '0;
            hdr_ff    <= '0;
            skip_ff   <= 1'b0;
         end else begin
            hist_ff   <= hist_in;
            in_nal_ff <= in_nal_in;
            pos_ff    <= pos_in;
            start_ff  <= start_in;
            prefix_ff <= prefix_in;
            cnt_ff    <= cnt_in;
            hdr_ff    <= hdr_in;
            skip_ff   <= skip_in;
         end
      end
   end

endmodule

>>> hdl/nus_queue.sv
// ----------------------------------------------------------------------------
// NAL unit splitter descriptor queue
// Small first-in first-out buffer between front end and back end.
// ----------------------------------------------------------------------------
module nus_queue import nus_pkg::*; #(
   parameter int DATA_W = nus_pair_bits(NUS_LENGTH_BITS, NUS_OFFSET_BITS),
   parameter int DEPTH  = NUS_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] wdata,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output logic [DATA_W-1:0] rdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]    count_ff, count_in;

   assign full      = (count_ff == (PTR_W+1)'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign rdata     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

>>> hdl/nus_back.sv
// ----------------------------------------------------------------------------
// NAL unit splitter back end
// Saturates lengths, decodes the header and drives the result register.
// ----------------------------------------------------------------------------
module nus_back import nus_pkg::*; #(
   parameter int LENGTH_BITS = NUS_LENGTH_BITS,
   parameter int OFFSET_BITS = NUS_OFFSET_BITS,
   parameter int PAIR_W      = nus_pair_bits(NUS_LENGTH_BITS, NUS_OFFSET_BITS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [MAX_LENGTH_W-1:0]  csr_max_length,
   input  logic                     q_not_empty,
   input  logic [PAIR_W-1:0]        q_rdata,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [OFFSET_OUT_W-1:0]  rsp_nal_offset,
   output logic [PREFIX_W-1:0]      rsp_prefix_len,
   output logic [PAYLOAD_OUT_W-1:0] rsp_payload_len,
   output logic                     rsp_forbidden_flag,
   output logic [1:0]               rsp_ref_idc,
   output logic [4:0]               rsp_unit_type,
   output logic                     rsp_oversize,
   output logic                     rsp_skipped_leading,
   output logic                     rsp_end_of_stream
);

   localparam int CNT_W = LENGTH_BITS + 1;
   localparam int CMP_W = (CNT_W > MAX_LENGTH_W) ? CNT_W : MAX_LENGTH_W;
   localparam int OFF_W = (OFFSET_BITS > OFFSET_OUT_W) ? OFFSET_BITS : OFFSET_OUT_W;
   localparam logic [CMP_W-1:0] LEN_CAP = CMP_W'((64'd1 << LENGTH_BITS) - 64'd1);

   typedef struct packed {
      logic [OFFSET_BITS-1:0] offset;
      logic [PREFIX_W-1:0]    prefix;
      logic [CNT_W-1:0]       len;
      logic [7:0]             hdr;
      logic                   skip;
      logic                   eos;
   } desc_type;

   typedef struct packed {
      logic     two;
      desc_type second;
      desc_type first;
   } pair_type;

   logic [MAX_LENGTH_W-1:0] max_len_ff;
   logic                    second_ff, second_in;
   logic                    valid_ff, valid_in;
   logic [OFFSET_OUT_W-1:0] offset_ff;
   logic [PREFIX_W-1:0]     prefix_ff;
   logic [PAYLOAD_OUT_W-1:0] payload_ff;
   logic [7:0]              hdr_ff;
   logic                    oversize_ff;
   logic                    skip_ff;
   logic                    eos_ff;

   pair_type            pair;
   desc_type            cur;
   logic                load;
   logic [CMP_W-1:0]    max_ext, limit, len_ext, pay;
   logic                big;
   logic [OFF_W-1:0]    off_ext;
   logic [7:0]          hdr_eff;

   assign csr_ready = 1'b1;

   assign pair = pair_type'(q_rdata);
   assign cur  = second_ff ? pair.second : pair.first;

   // Advance when the result register is empty or being taken
   assign load  = q_not_empty & (~valid_ff | ~rsp_stall);
   assign q_pop = load & (~pair.two | second_ff);

   always_comb begin
      second_in = second_ff;
      if (load) begin
         second_in = second_ff ? 1'b0 : pair.two;
      end
      valid_in = load | (valid_ff & rsp_stall);
   end

   // Saturate against the configured limit, capped at the counter range
   always_comb begin
      max_ext = CMP_W'(max_len_ff);
      limit   = (max_ext > LEN_CAP) ? LEN_CAP : max_ext;
      len_ext = CMP_W'(cur.len);
      big     = len_ext > limit;
      pay     = big ? limit : len_ext;
      off_ext = OFF_W'(cur.offset);
      hdr_eff = (cur.len == '0) ? 8'd0 : cur.hdr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LENGTH_RESET;
         second_ff  <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            max_len_ff <= csr_max_length;
         end
         second_ff <= second_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         offset_ff   <= off_ext[OFFSET_OUT_W-1:0];
         prefix_ff   <= cur.prefix;
         payload_ff  <= pay[PAYLOAD_OUT_W-1:0];
         hdr_ff      <= hdr_eff;
         oversize_ff <= big;
         skip_ff     <= cur.skip;
         eos_ff      <= cur.eos;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_nal_offset      = offset_ff;
   assign rsp_prefix_len      = prefix_ff;
   assign rsp_payload_len     = payload_ff;
   assign rsp_forbidden_flag  = hdr_ff[HDR_FORBIDDEN_POS];
   assign rsp_ref_idc         = hdr_ff[HDR_REF_IDC_HI:HDR_REF_IDC_LO];
   assign rsp_unit_type       = hdr_ff[HDR_TYPE_HI:0];
   assign rsp_oversize        = oversize_ff;
   assign rsp_skipped_leading = skip_ff;
   assign rsp_end_of_stream   = eos_ff;

endmodule

>>> hdl/annexb_nal_unit_splitter_top.sv
// ----------------------------------------------------------------------------
// Annex B NAL unit splitter
// Finds 3 and 4 byte start codes in a byte stream and reports one descriptor
// per NAL unit: offset, prefix length, saturated payload length and header.
// ----------------------------------------------------------------------------
//
//   channel   direction   flow control       carries
//   req_      in          valid / stall      data_byte, last_byte
//   rsp_      out         valid / stall      one NAL descriptor per transfer
//   csr_      in          valid / ready      max_length (always ready)
//
// One byte is taken per clock; req_stall rises only when the descriptor
// queue is full. A byte that closes a NAL and also ends the stream yields
// two descriptors, which leave one per clock while rsp_stall is low.
// A descriptor reaches rsp_ through the descriptor queue and result register.
// Reset is synchronous and active high; it clears the stream state and
// loads max_length with its default of 100000.
//
module annexb_nal_unit_splitter_top import nus_pkg::*; #(
   parameter int LENGTH_BITS = NUS_LENGTH_BITS,
   parameter int OFFSET_BITS = NUS_OFFSET_BITS,
   parameter int QUEUE_DEPTH = NUS_QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   // byte input
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_last_byte,
   // descriptor output
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [OFFSET_OUT_W-1:0]  rsp_nal_offset,
   output logic [PREFIX_W-1:0]      rsp_prefix_len,
   output logic [PAYLOAD_OUT_W-1:0] rsp_payload_len,
   output logic                     rsp_forbidden_flag,
   output logic [1:0]               rsp_ref_idc,
   output logic [4:0]               rsp_unit_type,
   output logic                     rsp_oversize,
   output logic                     rsp_skipped_leading,
   output logic                     rsp_end_of_stream,
   // configuration
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [MAX_LENGTH_W-1:0]  csr_max_length
);

   localparam int PAIR_W = nus_pair_bits(LENGTH_BITS, OFFSET_BITS);

   // Queue handshake between front end and back end
   logic              q_push;
   logic              q_pop;
   logic              q_full;
   logic              q_not_empty;
   logic [PAIR_W-1:0] q_wdata;
   logic [PAIR_W-1:0] q_rdata;

   // Front end: start code search and per-NAL counters
   nus_front #(
      .LENGTH_BITS (LENGTH_BITS),
      .OFFSET_BITS (OFFSET_BITS),
      .PAIR_W      (PAIR_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_wdata       (q_wdata)
   );

   // Decouple the two sides so each can stall on its own
   nus_queue #(
      .DATA_W (PAIR_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wdata     (q_wdata),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .rdata     (q_rdata)
   );

   // Back end: saturation, header decode, result register and the limit
   nus_back #(
      .LENGTH_BITS (LENGTH_BITS),
      .OFFSET_BITS (OFFSET_BITS),
      .PAIR_W      (PAIR_W)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_max_length      (csr_max_length),
      .q_not_empty         (q_not_empty),
      .q_rdata             (q_rdata),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_nal_offset      (rsp_nal_offset),
      .rsp_prefix_len      (rsp_prefix_len),
      .rsp_payload_len     (rsp_payload_len),
      .rsp_forbidden_flag  (rsp_forbidden_flag),
      .rsp_ref_idc         (rsp_ref_idc),
      .rsp_unit_type       (rsp_unit_type),
      .rsp_oversize        (rsp_oversize),
      .rsp_skipped_leading (rsp_skipped_leading),
      .rsp_end_of_stream   (rsp_end_of_stream)
   );

endmodule

>>> test/tb_annexb_nal_unit_splitter_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Annex B NAL unit splitter testbench
// Feeds byte streams into the splitter and checks every NAL descriptor against
// a local start-code tracker that runs beside the block, or against the typed
// row of the directed table. A short directed table comes first. It is followed
// by random streams, run under several max_length settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_annexb_nal_unit_splitter_top import nus_pkg::*; ();

   localparam int PERIOD       = 8;
   localparam int PHASES       = 6;
   localparam int PHASE_BYTES  = 120;   // random bytes per phase, roughly
   localparam int SETTLE       = 8;     // cycles to let the block go quiet
   localparam int QUIET_LIMIT  = 2000;  // cycles without any transfer
   localparam int PRINT_LIMIT  = 40;
   localparam int N_DIR        = 27;

   localparam logic [NUS_LENGTH_BITS:0] COUNT_CAP =
      (NUS_LENGTH_BITS+1)'((64'd1 << NUS_LENGTH_BITS) + 64'd3);

   // One NAL descriptor as it leaves the block
   typedef struct packed {
      logic [OFFSET_OUT_W-1:0]  offset;
      logic [PREFIX_W-1:0]      prefix;
      logic [PAYLOAD_OUT_W-1:0] payload;
      logic                     forbidden;
      logic [1:0]               ref_idc;
      logic [4:0]               unit_type;
      logic                     oversize;
      logic                     skipped;
      logic                     eos;
   } desc_type;

   // One row of the directed table; want is used only when typed is set
   typedef struct {
      logic [7:0] data;
      bit         last;
      bit         typed;
      desc_type   want;
   } row_type;

   localparam desc_type NO_DESC = '0;

   // Directed streams:
   //   1: 4-byte prefix at offset 0, short NAL closed by a 3-byte prefix, an
   //      empty NAL closed by a 4-byte prefix, a NAL closed by the last byte
   //   2: leading junk, then a start code completed by the last byte
   //   3: a lone last byte with no start code (no descriptor)
   //   4: a start code that is itself the end of the stream
   row_type dir_rows [N_DIR] = '{
      '{8'h00, 1'b0, 1'b0, NO_DESC},
      '{8'h00, 1'b0, 1'b0, NO_DESC},
      '{8'h00, 1'b0, 1'b0, NO_DESC},
      '{8'h01, 1'b0, 1'b0, NO_DESC},
      '{8'hFF, 1'b0, 1'b0, NO_DESC},
      '{8'hAB, 1'b0, 1'b0, NO_DESC},
      '{8'h00, 1'b0, 1'b0, NO_DESC},
      '{8'h00, 1'b0, 1'b0, NO_DESC},
      '{8'h01, 1'b0, 1'b1,
        '{32'd0, PREFIX_LONG, 24'd2, 1'b1, 2'd3, 5'd31, 1'b0, 1'b0, 1'b0}},
      '{8'h00, 1'b0, 1'b0, NO_DESC},
      '{8'h00, 1'b0, 1'b0, NO_DESC},
      '{8'h00, 1'b0, 1'b0, NO_DESC},
      '{8'h01, 1'b0, 1'b1,
        '{32'd6, PREFIX_SHORT, 24'd0, 1'b0, 2'd0, 5'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h65, 1'b0, 1'b0, NO_DESC},
      '{8'h00, 1'b1, 1'b1,
        '{32'd9, PREFIX_LONG, 24'd2, 1'b0, 2'd3, 5'd5, 1'b0, 1'b0, 1'b1}},
      '{8'h12, 1'b0, 1'b0, NO_DESC},
      '{8'h00, 1'b0, 1'b0, NO_DESC},
      '{8'h00, 1'b0, 1'b0, NO_DESC},
      '{8'h01, 1'b0, 1'b0, NO_DESC},
      '{8'h41, 1'b0, 1'b0, NO_DESC},
      '{8'h00, 1'b0, 1'b0, NO_DESC},
      '{8'h00, 1'b0, 1'b0, NO_DESC},
      '{8'h01, 1'b1, 1'b0, NO_DESC},
      '{8'h7E, 1'b1, 1'b0, NO_DESC},
      '{8'h00, 1'b0, 1'b0, NO_DESC},
      '{8'h00, 1'b0, 1'b0, NO_DESC},
      '{8'h01, 1'b1, 1'b1,
        '{32'd0, PREFIX_SHORT, 24'd0, 1'b0, 2'd0, 5'd0, 1'b0, 1'b0, 1'b1}}
   };

   // Clock, reset and block ports
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [7:0]               req_data_byte = 8'h00;
   logic                     req_last_byte = 1'b0;

   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [OFFSET_OUT_W-1:0]  rsp_nal_offset;
   logic [PREFIX_W-1:0]      rsp_prefix_len;
   logic [PAYLOAD_OUT_W-1:0] rsp_payload_len;
   logic                     rsp_forbidden_flag;
   logic [1:0]               rsp_ref_idc;
   logic [4:0]               rsp_unit_type;
   logic                     rsp_oversize;
   logic                     rsp_skipped_leading;
   logic                     rsp_end_of_stream;

   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [MAX_LENGTH_W-1:0]  csr_max_length = MAX_LENGTH_RESET;

   // Typed expectation that rides along with the byte being offered
   bit       row_typed = 1'b0;
   desc_type row_want  = '0;

   // Idle pattern of the current phase, in percent
   int sender_gap_pct = 0;
   int stall_pct      = 0;

   // Local copy of the splitter state
   logic [23:0]                hist;
   bit                         open_nal;
   logic [OFFSET_OUT_W-1:0]    pos;
   logic [OFFSET_OUT_W-1:0]    nal_pos;
   logic [PREFIX_W-1:0]        prefix;
   logic [NUS_LENGTH_BITS:0]   count;
   logic [7:0]                 hdr;
   bit                         skipped;
   logic [MAX_LENGTH_W-1:0]    nal_limit;

   desc_type nal_q [$];   // descriptors still owed by the block

   int errors        = 0;
   int bytes_taken   = 0;
   int desc_checked  = 0;
   int oversize_seen = 0;
   int eos_seen      = 0;
   int streams_sent  = 0;
   int quiet         = 0;

   annexb_nal_unit_splitter_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_last_byte       (req_last_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_nal_offset      (rsp_nal_offset),
      .rsp_prefix_len      (rsp_prefix_len),
      .rsp_payload_len     (rsp_payload_len),
      .rsp_forbidden_flag  (rsp_forbidden_flag),
      .rsp_ref_idc         (rsp_ref_idc),
      .rsp_unit_type       (rsp_unit_type),
      .rsp_oversize        (rsp_oversize),
      .rsp_skipped_leading (rsp_skipped_leading),
      .rsp_end_of_stream   (rsp_end_of_stream),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_max_length      (csr_max_length)
   );

   always #(PERIOD / 2) clock = ~clock;

   // Receiver back-pressure: decide the stall for the next edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // ------------------------------------------------------------------------
   // Start-code tracker
   // ------------------------------------------------------------------------

   // Return to the state of a fresh stream; the length limit is kept
   function automatic void clear_stream();
      hist     = HIST_RESET;
      open_nal = 1'b0;
      pos      = '0;
      nal_pos  = '0;
      prefix   = PREFIX_SHORT;
      count    = '0;
      hdr      = 8'h00;
      skipped  = 1'b0;
   endfunction

   // Build the descriptor of the NAL that is open now, with its true length
   function automatic desc_type close_nal(input logic [NUS_LENGTH_BITS:0] true_len,
                                          input bit eos);
      desc_type   d;
      logic [7:0] h;
      bit         big;
      big = true_len > nal_limit;
      // an empty NAL has no header byte
      h = (true_len != 0) ? hdr : 8'h00;
      d.offset    = nal_pos;
      d.prefix    = prefix;
      d.payload   = big ? nal_limit : true_len[PAYLOAD_OUT_W-1:0];
      d.forbidden = h[HDR_FORBIDDEN_POS];
      d.ref_idc   = h[HDR_REF_IDC_HI:HDR_REF_IDC_LO];
      d.unit_type = h[HDR_TYPE_HI:0];
      d.oversize  = big;
      d.skipped   = skipped;
      d.eos       = eos;
      return d;
   endfunction

   // Advance the tracker by one byte; return how many descriptors it closes
   function automatic int split_byte(input logic [7:0] b, input bit last,
                                     output desc_type first_out, output desc_type second_out);
      bit                       four;
      bit                       three;
      int                       zeros;
      logic [OFFSET_OUT_W-1:0]  start;
      logic [NUS_LENGTH_BITS:0] len;
      desc_type                 closing;
      int                       n;
      n          = 0;
      first_out  = NO_DESC;
      second_out = NO_DESC;
      four  = (hist == 24'h0) && (b == START_CODE_LAST);
      three = (hist[15:0] == 16'h0) && (b == START_CODE_LAST);
      if (three || four) begin
         zeros = four ? ZEROS_LONG : ZEROS_SHORT;
         start = pos - OFFSET_OUT_W'(zeros);
         if (open_nal) begin
            // the zeros of the new prefix were counted as payload: take them back
            len = (count >= zeros) ? count - (NUS_LENGTH_BITS+1)'(zeros) : '0;
            first_out = close_nal(len, 1'b0);
            n = 1;
         end else begin
            skipped = (start != 0);
         end
         open_nal = 1'b1;
         nal_pos  = start;
         prefix   = four ? PREFIX_LONG : PREFIX_SHORT;
         count    = '0;
         hdr      = 8'h00;
      end else if (open_nal) begin
         if (count == 0) hdr = b;
         if (count < COUNT_CAP) count++;
      end
      hist = {hist[15:0], b};
      pos  = pos + 1;
      if (last) begin
         if (open_nal) begin
            closing = close_nal(count, 1'b1);
            if (n == 0) first_out = closing;
            else second_out = closing;
            n++;
         end
         clear_stream();
      end
      return n;
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_error(input string what);
      if (errors < PRINT_LIMIT) $display("[%0t] ERROR: %s", $realtime, what);
      errors++;
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_error($sformatf("descriptor %0d field %s: got 0x%0h, want 0x%0h",
                                desc_checked, field, got, want));
   endtask

   task automatic check_desc(input desc_type want);
      check_field("nal_offset",      32'(rsp_nal_offset),      32'(want.offset));
      check_field("prefix_len",      32'(rsp_prefix_len),      32'(want.prefix));
      check_field("payload_len",     32'(rsp_payload_len),     32'(want.payload));
      check_field("forbidden_flag",  32'(rsp_forbidden_flag),  32'(want.forbidden));
      check_field("ref_idc",         32'(rsp_ref_idc),         32'(want.ref_idc));
      check_field("unit_type",       32'(rsp_unit_type),       32'(want.unit_type));
      check_field("oversize",        32'(rsp_oversize),        32'(want.oversize));
      check_field("skipped_leading", 32'(rsp_skipped_leading), 32'(want.skipped));
      check_field("end_of_stream",   32'(rsp_end_of_stream),   32'(want.eos));
   endtask

   // Sample every channel at the rising edge: track config writes, predict
   // for each byte taken, and check each descriptor handed over
   always @(posedge clock) begin
      desc_type pair [2];
      int       n;
      int       k;
      if (reset) begin
         clear_stream();
         nal_limit = MAX_LENGTH_RESET;
      end else begin
         if (csr_valid && csr_ready) nal_limit = csr_max_length;
         if (req_valid && !req_stall) begin
            bytes_taken++;
            n = split_byte(req_data_byte, req_last_byte, pair[0], pair[1]);
            // a typed row fixes the descriptor that this byte closes
            if (row_typed) begin
               if (n == 0) n = 1;
               pair[n - 1] = row_want;
            end
            for (k = 0; k < n; k++) nal_q.push_back(pair[k]);
         end
         if (rsp_valid && !rsp_stall) begin
            if (nal_q.size() == 0) begin
               report_error($sformatf("descriptor with none expected, offset 0x%0h",
                                      rsp_nal_offset));
            end else begin
               pair[0] = nal_q.pop_front();
               check_desc(pair[0]);
               if (pair[0].oversize) oversize_seen++;
               if (pair[0].eos) eos_seen++;
            end
            desc_checked++;
         end
      end
   end

   // Watchdog: end the run if no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
      end
      if (quiet == QUIET_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
         $display("annexb_nal_unit_splitter_top regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   // Offer one byte, starting at a falling edge; return at the falling edge
   // after the transfer. Valid stays high; gaps come only from sender_gap_pct.
   task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
                            input desc_type want);
      while ($urandom_range(0, 99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      row_typed     <= typed;
      row_want      <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Payload content biased toward zeros and ones so that false and real
   // start codes turn up inside NALs
   function automatic logic [7:0] payload_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return 8'h00;
      if (r < 33) return START_CODE_LAST;
      if (r < 36) return 8'h03;
      return 8'($urandom);
   endfunction

   // Build and send one stream: mostly well-formed NAL sequences, some noise
   task automatic send_random_stream();
      logic [7:0] sq [$];
      int         nals;
      int         plen;
      int         r;
      int         k;
      int         j;
      if ($urandom_range(0, 9) == 0) begin
         // noise: random bytes, start codes only by chance
         repeat ($urandom_range(1, 12)) sq.push_back(payload_byte());
      end else begin
         // junk ahead of the first start code now and then
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4)) sq.push_back(8'($urandom));
         nals = $urandom_range(1, 6);
         for (k = 0; k < nals; k++) begin
            if ($urandom_range(0, 1) == 1) sq.push_back(8'h00);
            sq.push_back(8'h00);
            sq.push_back(8'h00);
            sq.push_back(START_CODE_LAST);
            r = $urandom_range(0, 99);
            if (r < 80) plen = $urandom_range(0, 10);
            else if (r < 95) plen = $urandom_range(11, 40);
            else plen = $urandom_range(41, 150);
            // end the stream right on a start code now and then
            if (k == nals - 1 && $urandom_range(0, 6) == 0) plen = 0;
            if (plen > 0) sq.push_back(8'($urandom));
            for (j = 1; j < plen; j++) sq.push_back(payload_byte());
         end
      end
      for (k = 0; k < sq.size(); k++)
         send_byte(sq[k], k == sq.size() - 1, 1'b0, NO_DESC);
      streams_sent++;
   endtask

   // Drop valid and wait until every owed descriptor has come out, then let the
   // block go quiet for a stream end that owed nothing
   task automatic drain();
      req_valid <= 1'b0;
      while (nal_q.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_max_length(input logic [MAX_LENGTH_W-1:0] value);
      csr_valid      <= 1'b1;
      csr_max_length <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Main sequence: reset, then phases that each pick a limit and an idle
   // pattern; the directed table runs in the first phase at the reset limit
   initial begin
      int                      p;
      int                      i;
      int                      mode;
      int                      phase_start;
      logic [MAX_LENGTH_W-1:0] lim;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (p = 0; p < PHASES; p++) begin
         mode = p % 4;
         sender_gap_pct = (mode == 1) ? 64 : (mode == 3) ? 36 : 0;
         stall_pct      = (mode == 2) ? 64 : (mode == 3) ? 36 : 0;
         if (p > 0) begin
            case (p)
               1: lim = 24'd1;
               2: lim = {MAX_LENGTH_W{1'b1}};
               3: lim = '0;
               4: lim = MAX_LENGTH_W'($urandom_range(2, 40));
               default: lim = MAX_LENGTH_RESET;
            endcase
            write_max_length(lim);
         end else begin
            for (i = 0; i < N_DIR; i++)
               send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
                         dir_rows[i].want);
         end
         phase_start = bytes_taken;
         while (bytes_taken - phase_start < PHASE_BYTES) send_random_stream();
         drain();
      end
      $display("run covered %0d bytes in %0d random streams over %0d limit settings",
               bytes_taken, streams_sent, PHASES);
      $display("checked %0d descriptors: %0d saturated, %0d closed by end of stream",
               desc_checked, oversize_seen, eos_seen);
      if (errors == 0 && nal_q.size() == 0) begin
         $display("annexb_nal_unit_splitter_top regression: pass");
      end else begin
         $display("annexb_nal_unit_splitter_top regression: fail");
      end
      $finish;
   end

endmodule
